FILE: rtl/pls_pkg.sv
// shared types and constants for the positional list store
`default_nettype none

package pls_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int WORD_W = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_DELETE_AT  = 3'd5,
    CMD_DUMP       = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic edit;
    logic load_empty;
    logic dump_start;
    logic dump_step;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic dump_emit;
    logic dump_done;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/positional_list_store.sv
// top level of the positional list store
//
// An ordered list of signed 32-bit words with up to CAPACITY entries.
// Input channel (in_valid/in_stall) carries cmd, value and position; an item
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall) carries status, count, entry, last
// from a result register; the receiver holds it with out_stall.
// Edits (push/pop front or back, insert/delete at a position) shift every
// cell at once: the result register is loaded at the edge that takes the item,
// and a new item is taken every cycle while the result register drains.
// A dump rotates the list by one cell per cycle while the result register is
// free and emits the head each time; the input is held until the dump is done;
// results for the first 16 entries, the final one with last set.
// An empty dump gives one empty-status result.
// in_stall stays high during a dump and whenever a result is held by
// out_stall. Reset (rst, synchronous) empties the list and drops out_valid;
// cell contents are not cleared.
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pls_pkg::CMD_W-1:0]          cmd,
  input  logic signed [pls_pkg::WORD_W-1:0]  value,
  input  logic [pls_pkg::POS_W-1:0]          position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pls_pkg::STATUS_W-1:0]       status,
  output logic [pls_pkg::CNT_W-1:0]          count,
  output logic signed [pls_pkg::WORD_W-1:0]  entry,
  output logic                               last
);

  pls_pkg::dp_cmd_t ctl;
  pls_pkg::dp_sts_t sts;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts)
  );

  pls_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .cmd      (cmd),
    .value    (value),
    .position (position),
    .status   (status),
    .count    (count),
    .entry    (entry),
    .last     (last)
  );

endmodule

`default_nettype wire

FILE: rtl/pls_ctrl.sv
// controller state machine: handshakes and command sequencing
`default_nettype none

module pls_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic [pls_pkg::CMD_W-1:0]       cmd,
  output pls_pkg::dp_cmd_t                ctl,
  input  pls_pkg::dp_sts_t                sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    ctl            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            pls_pkg::CMD_PUSH_FRONT, pls_pkg::CMD_PUSH_BACK, pls_pkg::CMD_INSERT_AT,
            pls_pkg::CMD_POP_FRONT, pls_pkg::CMD_POP_BACK, pls_pkg::CMD_DELETE_AT: begin
              ctl.edit       = 1'b1;
              out_valid_next = 1'b1;
            end
            pls_pkg::CMD_DUMP: begin
              if (sts.fill_zero) begin
                ctl.load_empty = 1'b1;
                out_valid_next = 1'b1;
              end else begin
                ctl.dump_start = 1'b1;
                state_next     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl.dump_step = 1'b1;
          if (sts.dump_emit) begin
            out_valid_next = 1'b1;
          end
          if (sts.dump_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pls_dpath.sv
// datapath: shifting list cells, fill count, dump counter and result register
`default_nettype none

module pls_dpath #(
  parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pls_pkg::dp_cmd_t                   ctl,
  output pls_pkg::dp_sts_t                   sts,
  input  logic [pls_pkg::CMD_W-1:0]          cmd,
  input  logic signed [pls_pkg::WORD_W-1:0]  value,
  input  logic [pls_pkg::POS_W-1:0]          position,
  output logic [pls_pkg::STATUS_W-1:0]       status,
  output logic [pls_pkg::CNT_W-1:0]          count,
  output logic signed [pls_pkg::WORD_W-1:0]  entry,
  output logic                               last
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = ((FW > pls_pkg::POS_W) ? FW : pls_pkg::POS_W) + 1;

  logic signed [pls_pkg::WORD_W-1:0] cells      [CAPACITY];
  logic signed [pls_pkg::WORD_W-1:0] cells_next [CAPACITY];
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [IW-1:0] dcnt;
  logic [IW-1:0] dcnt_next;

  logic [CW-1:0] fill_x;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos1;
  logic [CW-1:0] idx;
  logic [CW-1:0] fill_new;
  logic [CW-1:0] dcnt_x;
  logic [CW-1:0] nemit;
  logic [CW-1:0] lim_x;
  logic          is_ins;
  logic          ins_ok;
  logic          del_ok;
  logic [pls_pkg::STATUS_W-1:0] edit_status;

  assign fill_x = CW'(fill);
  assign pos_x  = CW'(position);
  assign dcnt_x = CW'(dcnt);
  assign lim_x  = CW'(pls_pkg::RESULT_LIMIT);
  assign nemit  = (fill_x > lim_x) ? lim_x : fill_x;

  assign sts.fill_zero = (fill_x == '0);
  assign sts.dump_emit = (dcnt_x < lim_x);
  assign sts.dump_done = (dcnt_x == fill_x - CW'(1));

  // edit decode and checks
  always_comb begin
    is_ins = 1'b0;
    unique case (cmd)
      pls_pkg::CMD_PUSH_FRONT: begin pos1 = CW'(1);          is_ins = 1'b1; end
      pls_pkg::CMD_PUSH_BACK:  begin pos1 = fill_x + CW'(1); is_ins = 1'b1; end
      pls_pkg::CMD_INSERT_AT:  begin pos1 = pos_x;           is_ins = 1'b1; end
      pls_pkg::CMD_POP_FRONT:  pos1 = CW'(1);
      pls_pkg::CMD_POP_BACK:   pos1 = fill_x;
      pls_pkg::CMD_DELETE_AT:  pos1 = pos_x;
      default:                 pos1 = pos_x;
    endcase
    idx    = pos1 - CW'(1);
    ins_ok = 1'b0;
    del_ok = 1'b0;
    if (is_ins) begin
      if (pos1 == '0 || pos1 > fill_x + CW'(1)) begin
        edit_status = pls_pkg::ST_BADPOS;
      end else if (fill_x >= CW'(CAPACITY)) begin
        edit_status = pls_pkg::ST_FULL;
      end else begin
        edit_status = pls_pkg::ST_OK;
        ins_ok      = 1'b1;
      end
    end else begin
      if (fill_x == '0) begin
        edit_status = pls_pkg::ST_EMPTY;
      end else if (pos1 == '0 || pos1 > fill_x) begin
        edit_status = pls_pkg::ST_BADPOS;
      end else begin
        edit_status = pls_pkg::ST_OK;
        del_ok      = 1'b1;
      end
    end
    fill_new = fill_x;
    if (ins_ok) begin
      fill_new = fill_x + CW'(1);
    end else if (del_ok) begin
      fill_new = fill_x - CW'(1);
    end
  end

  // cell shifting: open a gap, close a gap, or rotate by one for dump
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (ctl.edit && ins_ok) begin
        if (CW'(i) == idx) begin
          cells_next[i] = value;
        end else if (CW'(i) > idx) begin
          cells_next[i] = cells[(i == 0) ? 0 : i - 1];
        end
      end else if (ctl.edit && del_ok) begin
        if (CW'(i) >= idx) begin
          cells_next[i] = cells[(i == CAPACITY - 1) ? i : i + 1];
        end
      end else if (ctl.dump_step) begin
        if (CW'(i) == fill_x - CW'(1)) begin
          cells_next[i] = cells[0];
        end else begin
          cells_next[i] = cells[(i == CAPACITY - 1) ? i : i + 1];
        end
      end
    end
  end

  always_comb begin
    fill_next = fill;
    if (ctl.edit) begin
      fill_next = fill_new[FW-1:0];
    end
    dcnt_next = dcnt;
    if (ctl.dump_start) begin
      dcnt_next = '0;
    end else if (ctl.dump_step) begin
      dcnt_next = dcnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      dcnt <= '0;
    end else begin
      fill <= fill_next;
      dcnt <= dcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.edit) begin
      status <= edit_status;
      count  <= fill_new[pls_pkg::CNT_W-1:0];
      entry  <= '0;
      last   <= 1'b1;
    end else if (ctl.load_empty) begin
      status <= pls_pkg::ST_EMPTY;
      count  <= '0;
      entry  <= '0;
      last   <= 1'b1;
    end else if (ctl.dump_step && sts.dump_emit) begin
      status <= pls_pkg::ST_OK;
      count  <= fill_x[pls_pkg::CNT_W-1:0];
      entry  <= cells[0];
      last   <= (dcnt_x == nemit - CW'(1));
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/pls_list_mirror_pkg.sv
// shadow copy of the positional list and the queue of results still owed by the block
package pls_list_mirror_pkg;

  localparam logic [pls_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct {
    pls_pkg::status_t                  st;
    logic [pls_pkg::CNT_W-1:0]         cnt;
    logic signed [pls_pkg::WORD_W-1:0] word;
    logic                              fin;
  } list_result_t;

  class list_mirror;
    logic signed [pls_pkg::WORD_W-1:0] cells[pls_pkg::DEF_CAPACITY];
    int fill = 0;
    list_result_t owed[$];
    int errors = 0;
    int checked = 0;
    int items = 0;
    int stat_seen[4] = '{0, 0, 0, 0};

    function void queue_result(pls_pkg::status_t s, logic signed [pls_pkg::WORD_W-1:0] w,
                               logic l);
      list_result_t r;
      r.st = s;
      r.cnt = fill[pls_pkg::CNT_W-1:0];
      r.word = w;
      r.fin = l;
      owed.push_back(r);
      stat_seen[s]++;
    endfunction

    function pls_pkg::status_t insert_word(int pos1, logic signed [pls_pkg::WORD_W-1:0] w);
      if (pos1 < 1 || pos1 > fill + 1) return pls_pkg::ST_BADPOS;
      if (fill >= pls_pkg::DEF_CAPACITY) return pls_pkg::ST_FULL;
      for (int i = fill; i > pos1 - 1; i--) cells[i] = cells[i-1];
      cells[pos1-1] = w;
      fill++;
      return pls_pkg::ST_OK;
    endfunction

    function pls_pkg::status_t remove_word(int pos1);
      if (fill == 0) return pls_pkg::ST_EMPTY;
      if (pos1 < 1 || pos1 > fill) return pls_pkg::ST_BADPOS;
      for (int i = pos1 - 1; i + 1 < fill; i++) cells[i] = cells[i+1];
      fill--;
      return pls_pkg::ST_OK;
    endfunction

    function void note_item(logic [pls_pkg::CMD_W-1:0] c, logic signed [pls_pkg::WORD_W-1:0] w,
                            logic [pls_pkg::POS_W-1:0] p);
      pls_pkg::status_t s;
      int n;
      items++;
      case (c)
        pls_pkg::CMD_PUSH_FRONT: s = insert_word(1, w);
        pls_pkg::CMD_PUSH_BACK:  s = insert_word(fill + 1, w);
        pls_pkg::CMD_INSERT_AT:  s = insert_word(int'(p), w);
        pls_pkg::CMD_POP_FRONT:  s = remove_word(1);
        pls_pkg::CMD_POP_BACK:   s = remove_word(fill);
        pls_pkg::CMD_DELETE_AT:  s = remove_word(int'(p));
        pls_pkg::CMD_DUMP: begin
          if (fill == 0) begin
            queue_result(pls_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            n = (fill > pls_pkg::RESULT_LIMIT) ? pls_pkg::RESULT_LIMIT : fill;
            for (int i = 0; i < n; i++) queue_result(pls_pkg::ST_OK, cells[i], i == n - 1);
          end
          return;
        end
        default: return;
      endcase
      queue_result(s, '0, 1'b1);
    endfunction

    function void check_result(logic [pls_pkg::STATUS_W-1:0] s, logic [pls_pkg::CNT_W-1:0] n,
                               logic signed [pls_pkg::WORD_W-1:0] w, logic l);
      list_result_t want;
      if (owed.size() == 0) begin
        $error("result with nothing owed: status %0d count %0d entry %0d last %0b",
               s, n, w, l);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (s !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, s);
        errors++;
      end
      if (n !== want.cnt) begin
        $error("count: expected %0d, got %0d", want.cnt, n);
        errors++;
      end
      if (w !== want.word) begin
        $error("entry: expected %0d, got %0d", want.word, w);
        errors++;
      end
      if (l !== want.fin) begin
        $error("last: expected %0b, got %0b", want.fin, l);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass
endpackage

FILE: tb/sv/tb_positional_list_store.sv
// self-checking testbench for the positional list store
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 347;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 150;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [pls_pkg::CMD_W-1:0] cmd;
  logic signed [pls_pkg::WORD_W-1:0] value;
  logic [pls_pkg::POS_W-1:0] position;
  logic out_valid;
  logic out_stall;
  logic [pls_pkg::STATUS_W-1:0] status;
  logic [pls_pkg::CNT_W-1:0] count;
  logic signed [pls_pkg::WORD_W-1:0] entry;
  logic last;

  logic hold_long;
  pls_list_mirror_pkg::list_mirror mirror;
  int accepted = 0;
  int quiet_left = 0;
  int cycles = 0;
  int stall_left = 0;
  int free_left = 0;

  positional_list_store dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .value(value), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .count(count), .entry(entry), .last(last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [pls_pkg::WORD_W-1:0] pick_word();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic send_item(input logic [pls_pkg::CMD_W-1:0] c,
                           input logic signed [pls_pkg::WORD_W-1:0] v,
                           input logic [pls_pkg::POS_W-1:0] p);
    int gap;
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      gap = pick_idle_len();
      if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    value <= v;
    position <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    accepted++;
    mirror.note_item(c, v, p);
  endtask

  task automatic random_step(inout bit growing, output bit counted);
    int r;
    int n;
    int sub;
    int pr;
    logic [pls_pkg::CMD_W-1:0] c;
    logic signed [pls_pkg::WORD_W-1:0] v;
    logic [pls_pkg::POS_W-1:0] p;
    n = mirror.fill;
    v = pick_word();
    pr = $urandom_range(0, 31);
    p = pr[pls_pkg::POS_W-1:0];
    if (growing && n == pls_pkg::DEF_CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if (!growing && n == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
    r = $urandom_range(0, 99);
    sub = $urandom_range(0, 2);
    if (r < 4) begin
      c = pls_list_mirror_pkg::CMD_UNUSED;
    end else if (r < 10) begin
      c = pls_pkg::cmd_t'($urandom_range(0, 6));
    end else if (r < 18) begin
      c = pls_pkg::CMD_DUMP;
    end else if (($urandom_range(0, 99) < 75) == growing) begin
      case (sub)
        0: c = pls_pkg::CMD_PUSH_FRONT;
        1: c = pls_pkg::CMD_PUSH_BACK;
        default: begin
          c = pls_pkg::CMD_INSERT_AT;
          if ($urandom_range(0, 9) != 0) begin
            pr = $urandom_range(1, n + 1);
            p = pr[pls_pkg::POS_W-1:0];
          end
        end
      endcase
    end else begin
      case (sub)
        0: c = pls_pkg::CMD_POP_FRONT;
        1: c = pls_pkg::CMD_POP_BACK;
        default: begin
          c = pls_pkg::CMD_DELETE_AT;
          if (n > 0 && $urandom_range(0, 9) != 0) begin
            pr = $urandom_range(1, n);
            p = pr[pls_pkg::POS_W-1:0];
          end
        end
      endcase
    end
    counted = (c != pls_list_mirror_pkg::CMD_UNUSED);
    send_item(c, v, p);
  endtask

  // result side: random stalls, plus the long hold-off from the pressure process
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      free_left = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        mirror.check_result(status, count, entry, last);
      if (stall_left == 0 && free_left == 0) begin
        stall_left = pick_idle_len();
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        free_left--;
        out_stall <= hold_long;
      end
    end
  end

  initial begin
    hold_long = 1'b0;
    wait (accepted >= 80);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** positional_list_store: FAILED **");
      $finish;
    end
  end

  initial begin
    bit growing;
    bit counted;
    int done;
    mirror = new;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    value = '0;
    position = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_item(pls_pkg::CMD_DUMP, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_POP_FRONT, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_POP_BACK, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_DELETE_AT, 32'sd0, 5'd31);
    send_item(pls_pkg::CMD_INSERT_AT, 32'sd7, 5'd0);
    send_item(pls_pkg::CMD_INSERT_AT, 32'sd7, 5'd2);
    // build and edit a short list
    send_item(pls_pkg::CMD_PUSH_FRONT, 32'sh8000_0000, 5'd0);
    send_item(pls_pkg::CMD_PUSH_BACK, 32'sh7fff_ffff, 5'd0);
    send_item(pls_pkg::CMD_INSERT_AT, -32'sd1, 5'd3);
    send_item(pls_pkg::CMD_INSERT_AT, 32'sd0, 5'd1);
    send_item(pls_pkg::CMD_INSERT_AT, 32'sd5, 5'd31);
    send_item(pls_pkg::CMD_DELETE_AT, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_DELETE_AT, 32'sd0, 5'd5);
    send_item(pls_pkg::CMD_DELETE_AT, 32'sd0, 5'd2);
    send_item(pls_list_mirror_pkg::CMD_UNUSED, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_DUMP, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_POP_FRONT, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_POP_BACK, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_DELETE_AT, 32'sd0, 5'd1);
    send_item(pls_pkg::CMD_POP_FRONT, 32'sd0, 5'd0);
    send_item(pls_pkg::CMD_PUSH_BACK, 32'sh5555_5555, 5'd0);
    send_item(pls_pkg::CMD_PUSH_FRONT, 32'shaaaa_aaaa, 5'd0);
    send_item(pls_pkg::CMD_DUMP, 32'sd0, 5'd0);

    // random part swings between growing to full and shrinking to empty
    growing = 1'b1;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      random_step(growing, counted);
      if (counted) done++;
    end

    in_valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items (%0d random), %0d results checked, %0d mismatches",
             accepted, done, mirror.checked, mirror.errors);
    $display("statuses: ok %0d, bad position %0d, full %0d, empty %0d",
             mirror.stat_seen[pls_pkg::ST_OK], mirror.stat_seen[pls_pkg::ST_BADPOS],
             mirror.stat_seen[pls_pkg::ST_FULL], mirror.stat_seen[pls_pkg::ST_EMPTY]);
    if (mirror.errors == 0) begin
      $display("** positional_list_store: PASSED **");
    end else begin
      $display("** positional_list_store: FAILED **");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/pls_pkg.sv
rtl/pls_ctrl.sv
rtl/pls_dpath.sv
rtl/positional_list_store.sv
tb/sv/pls_list_mirror_pkg.sv
tb/sv/tb_positional_list_store.sv
